// File: design/twdkr_pkg.sv
// ----------------------------------------------------------------------------
// twdkr_pkg
// Shared types and constants for the two-wheel duty kinematics ramp core.
// ----------------------------------------------------------------------------
package twdkr_pkg;

    // apb register map
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        REG_WHEEL_LAYOUT = 2'd0,
        REG_SLEW_STEP    = 2'd1,
        REG_ACCEPT_ID    = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    // register reset values
    localparam logic        LAYOUT_RST    = 1'b1;
    localparam logic [15:0] SLEW_STEP_RST = 16'd32768;
    localparam logic [10:0] ACCEPT_ID_RST = 11'd1;

    // command frame length that is taken
    localparam logic [3:0] FRAME_LEN_CMD = 4'd6;

    // item operations
    typedef enum logic {
        OP_CMD  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        op_t                operation;
        logic [10:0]        frame_id;
        logic [3:0]         frame_len;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vr;
    } in_item_t;

    typedef struct packed {
        logic [14:0] fwd_duty_a;
        logic [14:0] rev_duty_a;
        logic [14:0] fwd_duty_b;
        logic [14:0] rev_duty_b;
        logic        frame_taken;
    } out_item_t;

    typedef struct packed {
        logic        wheel_layout;
        logic [15:0] slew_step;
        logic [10:0] accept_id;
    } cfg_t;

endpackage

// File: design/twdkr_apb_regs.sv
// ----------------------------------------------------------------------------
// twdkr_apb_regs
// APB configuration registers: wheel layout, slew step and accepted frame id.
// ----------------------------------------------------------------------------
module twdkr_apb_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [twdkr_pkg::ADDR_W-1:0] paddr,
    input  logic [twdkr_pkg::DATA_W-1:0] pwdata,
    output logic [twdkr_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output twdkr_pkg::cfg_t            cfg
);
    import twdkr_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wheel_layout <= LAYOUT_RST;
            cfg_reg.slew_step    <= SLEW_STEP_RST;
            cfg_reg.accept_id    <= ACCEPT_ID_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_WHEEL_LAYOUT: cfg_reg.wheel_layout <= pwdata[0];
                REG_SLEW_STEP:    cfg_reg.slew_step    <= pwdata[15:0];
                REG_ACCEPT_ID:    cfg_reg.accept_id    <= pwdata[10:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_WHEEL_LAYOUT: prdata[0]     = cfg_reg.wheel_layout;
            REG_SLEW_STEP:    prdata[15:0]  = cfg_reg.slew_step;
            REG_ACCEPT_ID:    prdata[10:0]  = cfg_reg.accept_id;
            default:          prdata        = '0;
        endcase
    end

endmodule

// File: design/twdkr_kin.sv
// ----------------------------------------------------------------------------
// twdkr_kin
// Wheel kinematics: velocities to signed Q.15 target duties, rounded and
// saturated.
// ----------------------------------------------------------------------------
module twdkr_kin (
    input  logic               wheel_layout,
    input  logic signed [15:0] vx,
    input  logic signed [15:0] vy,
    input  logic signed [15:0] vr,
    output logic signed [15:0] target_a,
    output logic signed [15:0] target_b
);
    import twdkr_pkg::*;

    // linear and rotation gains in q16
    localparam logic signed [17:0] KL_Q16 = 18'sd105164;
    localparam logic signed [21:0] KR_Q16 = 22'sd1557436;
    localparam int unsigned        SUM_W  = 38;
    localparam logic [14:0]        DUTY_MAX = 15'd32767;

    logic signed [16:0]      diff_a;
    logic signed [16:0]      sum_b;
    logic signed [34:0]      lin_a;
    logic signed [34:0]      lin_b;
    logic signed [37:0]      rot;
    logic signed [SUM_W-1:0] rot_s;
    logic signed [SUM_W-1:0] acc_a;
    logic signed [SUM_W-1:0] acc_b;

    // round half away from zero to q.15, then clamp to +-32767
    function automatic logic signed [15:0] q16_to_duty(input logic signed [SUM_W-1:0] s);
        logic             neg;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] rnd;
        logic [14:0]      q;
        neg = s[SUM_W-1];
        mag = neg ? SUM_W'(-s) : SUM_W'(s);
        rnd = mag + SUM_W'(32768);
        q   = (rnd[SUM_W-1:16] > {{(SUM_W-31){1'b0}}, DUTY_MAX}) ? DUTY_MAX : rnd[30:16];
        return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    assign diff_a = {vy[15], vy} - {vx[15], vx};
    assign sum_b  = {vx[15], vx} + {vy[15], vy};
    assign lin_a  = diff_a * KL_Q16;
    assign lin_b  = sum_b * KL_Q16;
    assign rot    = vr * KR_Q16;
    assign rot_s  = wheel_layout ? rot : -rot;
    assign acc_a  = SUM_W'(lin_a) + rot_s;
    assign acc_b  = SUM_W'(lin_b) - rot_s;

    assign target_a = q16_to_duty(acc_a);
    assign target_b = q16_to_duty(acc_b);

endmodule

// File: design/twdkr_ramp.sv
// ----------------------------------------------------------------------------
// twdkr_ramp
// Current duty of one wheel, moved toward its target by at most the slew step
// on each tick.
// ----------------------------------------------------------------------------
module twdkr_ramp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               tick,
    input  logic signed [15:0] target,
    input  logic [15:0]        slew_step,
    output logic signed [15:0] cur_next
);
    logic signed [15:0] cur_reg;
    logic signed [17:0] cur_x;
    logic signed [17:0] tgt_x;
    logic signed [17:0] up;
    logic signed [17:0] dn;
    logic signed [17:0] ramped;

    assign cur_x = {{2{cur_reg[15]}}, cur_reg};
    assign tgt_x = {{2{target[15]}}, target};
    assign up    = cur_x + $signed({2'b00, slew_step});
    assign dn    = cur_x - $signed({2'b00, slew_step});

    always_comb begin
        if (tgt_x > cur_x) begin
            ramped = (up < tgt_x) ? up : tgt_x;
        end else begin
            ramped = (dn > tgt_x) ? dn : tgt_x;
        end
    end

    // result always lies between current and target, so 16 bits hold it
    assign cur_next = tick ? ramped[15:0] : cur_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else begin
            cur_reg <= cur_next;
        end
    end

endmodule

// File: design/two_wheel_duty_kinematics_ramp_core.sv
// ----------------------------------------------------------------------------
// two_wheel_duty_kinematics_ramp_core
// Two-wheel kinematics with slew-limited duty ramp: command frames set the
// wheel target duties, ramp ticks move the current duties toward them, and
// every item reports the current duties as forward and reverse magnitudes.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    twdkr_pkg::in_item_t
//  m_        out        m_valid / m_ready    twdkr_pkg::out_item_t
//  apb       in/out     psel/penable/pready  paddr[3:0], pwdata/prdata 32 bit
//
//  one item per cycle sustained while m_ready holds; a result passes the
//  input register, then the result register around the kinematics multiply,
//  round, clamp and ramp logic
//  reset (aresetn low, synchronous) clears both stages, targets and current
//  duties, and loads the register defaults
//  a stalled result holds in the result register while the input register
//  still takes one more transfer; s_ready drops only when both are full
//
module two_wheel_duty_kinematics_ramp_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // item input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  twdkr_pkg::in_item_t          s_item,
    // result output
    output logic                         m_valid,
    input  logic                         m_ready,
    output twdkr_pkg::out_item_t         m_item,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twdkr_pkg::ADDR_W-1:0] paddr,
    input  logic [twdkr_pkg::DATA_W-1:0] pwdata,
    output logic [twdkr_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import twdkr_pkg::*;

    cfg_t      cfg;

    // input register stage
    logic      in_valid_reg;
    in_item_t  in_item_reg;

    // result register stage
    logic      m_valid_reg;
    out_item_t m_item_reg;
    out_item_t m_item_next;

    // wheel targets, signed q.15
    logic signed [15:0] target_a_reg;
    logic signed [15:0] target_b_reg;
    logic signed [15:0] target_a_next;
    logic signed [15:0] target_b_next;

    logic signed [15:0] cur_a_next;
    logic signed [15:0] cur_b_next;

    logic advance;
    logic is_tick;
    logic take;

    // ---------------- configuration registers ----------------
    twdkr_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- handshake ----------------
    // the input stage moves on when the result register is empty or draining
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // ---------------- command decode ----------------
    assign is_tick = (in_item_reg.operation == OP_TICK);
    // command frame taken only from the configured id with a six-byte payload
    assign take    = !is_tick
                     && (in_item_reg.frame_id == cfg.accept_id)
                     && (in_item_reg.frame_len == FRAME_LEN_CMD);

    // ---------------- kinematics ----------------
    twdkr_kin u_kin (
        .wheel_layout (cfg.wheel_layout),
        .vx           (in_item_reg.vx),
        .vy           (in_item_reg.vy),
        .vr           (in_item_reg.vr),
        .target_a     (target_a_next),
        .target_b     (target_b_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_a_reg <= '0;
            target_b_reg <= '0;
        end else if (advance && take) begin
            target_a_reg <= target_a_next;
            target_b_reg <= target_b_next;
        end
    end

    // ---------------- slew ramps ----------------
    // a command leaves the current duties alone; only ticks move them
    twdkr_ramp u_ramp_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick      (advance && is_tick),
        .target    (target_a_reg),
        .slew_step (cfg.slew_step),
        .cur_next  (cur_a_next)
    );

    twdkr_ramp u_ramp_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick      (advance && is_tick),
        .target    (target_b_reg),
        .slew_step (cfg.slew_step),
        .cur_next  (cur_b_next)
    );

    // ---------------- result formatting ----------------
    // split each signed duty into forward and reverse magnitudes
    always_comb begin
        m_item_next.fwd_duty_a  = (cur_a_next > 16'sd0) ? cur_a_next[14:0] : '0;
        m_item_next.rev_duty_a  = (cur_a_next < 16'sd0) ? 15'(-cur_a_next) : '0;
        m_item_next.fwd_duty_b  = (cur_b_next > 16'sd0) ? cur_b_next[14:0] : '0;
        m_item_next.rev_duty_b  = (cur_b_next < 16'sd0) ? 15'(-cur_b_next) : '0;
        m_item_next.frame_taken = take;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_item_reg <= m_item_next;
        end
    end

`ifndef SYNTH
    // an item leaving the input stage always lands in the result register
    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("result register not loaded after advance");

    // a ramp tick never reports a taken frame
    a_tick_not_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_tick) |=> !m_item_reg.frame_taken)
        else $error("tick reported as taken frame");

    // forward and reverse magnitudes of one wheel never both nonzero
    a_dir_excl_a: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_item_reg.fwd_duty_a == '0 || m_item_reg.rev_duty_a == '0))
        else $error("wheel a driven both directions");

    a_dir_excl_b: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_item_reg.fwd_duty_b == '0 || m_item_reg.rev_duty_b == '0))
        else $error("wheel b driven both directions");

    // saturation keeps targets inside +-32767
    a_target_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (target_a_reg != 16'sh8000) && (target_b_reg != 16'sh8000))
        else $error("target duty out of range");
`endif

endmodule
